### design/ac_rms_power_meter_macros.svh
// ----------------------------------------------------------------------------
// AC RMS power meter assertion macros
// Short forms for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef AC_RMS_POWER_METER_MACROS_SVH
`define AC_RMS_POWER_METER_MACROS_SVH

// Same-cycle implication.
`define ACRMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/acrms_pkg.sv
// ----------------------------------------------------------------------------
// AC RMS power meter package
// Shared widths, reset values and the arithmetic unit request type.
// ----------------------------------------------------------------------------
package acrms_pkg;

  localparam int unsigned MAX_WINDOW_SAMPLES = 4096;

  // Word width of the shared iterative unit
  localparam int unsigned AW = 64;

  localparam int unsigned VOLT_W  = 12;
  localparam int unsigned CURR_W  = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VGAIN_W = 9;
  localparam int unsigned IGAIN_W = 8;
  localparam int unsigned PFMIN_W = 10;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam int unsigned SC_W   = 13;
  localparam int unsigned RV_W   = 18;
  localparam int unsigned RI_W   = 20;
  localparam int unsigned ACT_W  = 26;
  localparam int unsigned APP_W  = 25;
  localparam int unsigned PF_W   = 16;
  localparam int unsigned FREQ_W = 24;
  localparam int unsigned CC_W   = 12;

  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 144;

  localparam logic [VGAIN_W-1:0] VGAIN_RST  = 9'd264;
  localparam logic [IGAIN_W-1:0] IGAIN_RST  = 8'd20;
  localparam logic [PFMIN_W-1:0] PFMIN_RST  = 10'd1;
  localparam logic [VOLT_W-1:0]  OFFSET_RST = 12'd1500;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

endpackage

### design/acrms_arith.sv
// ----------------------------------------------------------------------------
// AC RMS shared arithmetic unit
// One result bit per cycle: shift-add multiply, restoring divide, and
// digit-by-digit integer square root, all modulo 2^64.
// ----------------------------------------------------------------------------
module acrms_arith (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  acrms_pkg::arith_req_t        req_i,
  input  logic [acrms_pkg::AW-1:0]     a_i,
  input  logic [acrms_pkg::AW-1:0]     b_i,
  output logic                         done_o,
  output logic [acrms_pkg::AW-1:0]     res_o
);

  localparam int unsigned AW    = acrms_pkg::AW;
  localparam int unsigned CNT_W = $clog2(AW);
  localparam logic [AW-1:0] SQRT_BIT0 = {2'b01, {(AW-2){1'b0}}};

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  acrms_pkg::arith_op_e op_q, op_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [AW-1:0]        x_q, x_d;
  logic [AW-1:0]        y_q, y_d;
  logic [AW:0]          rem_sh;
  logic [AW:0]          rem_sub;
  logic [AW-1:0]        trial;
  logic                 last;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    op_d    = op_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    last    = 1'b0;
    rem_sh  = {acc_q, x_q[AW-1]};
    rem_sub = rem_sh - {1'b0, y_q};
    trial   = acc_q + y_q;

    if (req_i.start) begin
      op_d   = req_i.op;
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      x_d    = a_i;
      y_d    = (req_i.op == acrms_pkg::OP_SQRT) ? SQRT_BIT0 : b_i;
    end else if (busy_q) begin
      case (op_q)
        acrms_pkg::OP_MUL: begin
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d  = x_q << 1;
          y_d  = y_q >> 1;
          last = (cnt_q == CNT_W'(AW - 1));
        end
        acrms_pkg::OP_DIV: begin
          if (!rem_sub[AW]) begin
            acc_d = rem_sub[AW-1:0];
            x_d   = {x_q[AW-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[AW-1:0];
            x_d   = {x_q[AW-2:0], 1'b0};
          end
          last = (cnt_q == CNT_W'(AW - 1));
        end
        acrms_pkg::OP_SQRT: begin
          if (x_q >= trial) begin
            x_d   = x_q - trial;
            acc_d = (acc_q >> 1) + y_q;
          end else begin
            acc_d = acc_q >> 1;
          end
          y_d  = y_q >> 2;
          last = (cnt_q == CNT_W'(AW / 2 - 1));
        end
        default: begin
          last = 1'b1;
        end
      endcase
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= acrms_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == acrms_pkg::OP_DIV) ? x_q : acc_q;

endmodule

### design/ac_rms_power_meter.sv
// ----------------------------------------------------------------------------
// AC RMS power meter
// Accumulates offset-corrected voltage/current statistics per window and
// reports RMS values, power, power factor and line frequency at window end.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake              | Contents
// ---------+-----+------------------------+------------------------------------
// s_axis   | in  | tvalid/tready          | one sample pair, tlast = window end
// m_axis   | out | tvalid/tready          | one window result, tuser = overflow
// cfg      | in  | cfg_we_i (no wait)     | gain and threshold registers
//
// Steps per sample: accept, the bit-serial square/product MAC, one
// accumulate. A window-end sample adds a sequence of 23 operations on the
// shared iterative unit (12 multiplies, 9 divides and 2 square roots).
// Reset clears the window sums and restores offsets 1500 mV and register
// defaults. A stalled result waits in the output register; new samples are
// still taken, and only the next window result waits for it to drain.
// ----------------------------------------------------------------------------
module ac_rms_power_meter #(
  parameter int unsigned MAX_WINDOW_SAMPLES = acrms_pkg::MAX_WINDOW_SAMPLES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // volt_mv[11:0], curr_mv[23:12], time_us[55:24]
  input  logic [acrms_pkg::S_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sample_count[12:0], rms_voltage[30:13], rms_current[50:31],
  // active_power[76:51], apparent_power[101:77], power_factor[117:102],
  // frequency[141:118], zero pad[143:142]
  output logic [acrms_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // overflow[0]
  output logic                               m_axis_tuser,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [acrms_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [acrms_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW      = acrms_pkg::AW;
  localparam int unsigned VOLT_W  = acrms_pkg::VOLT_W;
  localparam int unsigned CURR_W  = acrms_pkg::CURR_W;
  localparam int unsigned TIME_W  = acrms_pkg::TIME_W;
  localparam int unsigned CC_W    = acrms_pkg::CC_W;
  localparam int unsigned LOG_MAX = $clog2(MAX_WINDOW_SAMPLES);
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int unsigned RAWV_W  = VOLT_W + LOG_MAX;
  localparam int unsigned RAWI_W  = CURR_W + LOG_MAX;
  localparam int unsigned MAG_W   = VOLT_W;
  localparam int unsigned PROD_W  = 2 * MAG_W;
  localparam int unsigned SQ_W    = PROD_W + LOG_MAX;
  localparam int unsigned PS_W    = SQ_W + 1;
  localparam int unsigned MACC_W  = $clog2(MAG_W);

  // Register indexes
  localparam logic [acrms_pkg::CFG_ADDR_W-1:0] REG_VGAIN = 2'd0;
  localparam logic [acrms_pkg::CFG_ADDR_W-1:0] REG_IGAIN = 2'd1;
  localparam logic [acrms_pkg::CFG_ADDR_W-1:0] REG_PFMIN = 2'd2;

  // Control states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_END  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  // Window-end sequence steps
  localparam logic [4:0] SP_GV2   = 5'd0;
  localparam logic [4:0] SP_SV    = 5'd1;
  localparam logic [4:0] SP_D100  = 5'd2;
  localparam logic [4:0] SP_QV    = 5'd3;
  localparam logic [4:0] SP_RTV   = 5'd4;
  localparam logic [4:0] SP_GI2   = 5'd5;
  localparam logic [4:0] SP_SI    = 5'd6;
  localparam logic [4:0] SP_QI    = 5'd7;
  localparam logic [4:0] SP_RTI   = 5'd8;
  localparam logic [4:0] SP_PV    = 5'd9;
  localparam logic [4:0] SP_SCALE = 5'd10;
  localparam logic [4:0] SP_D1E5  = 5'd11;
  localparam logic [4:0] SP_AMAG  = 5'd12;
  localparam logic [4:0] SP_VA    = 5'd13;
  localparam logic [4:0] SP_APP   = 5'd14;
  localparam logic [4:0] SP_THR   = 5'd15;
  localparam logic [4:0] SP_D10   = 5'd16;
  localparam logic [4:0] SP_A5    = 5'd17;
  localparam logic [4:0] SP_PF    = 5'd18;
  localparam logic [4:0] SP_E9    = 5'd19;
  localparam logic [4:0] SP_FREQ  = 5'd20;
  localparam logic [4:0] SP_VOFF  = 5'd21;
  localparam logic [4:0] SP_IOFF  = 5'd22;

  localparam logic [AW-1:0] K_10     = 64'd10;
  localparam logic [AW-1:0] K_100    = 64'd100;
  localparam logic [AW-1:0] K_1000   = 64'd1000;
  localparam logic [AW-1:0] K_5000   = 64'd5000;
  localparam logic [AW-1:0] K_10000  = 64'd10000;
  localparam logic [AW-1:0] K_100000 = 64'd100000;
  localparam logic [AW-1:0] K_1E9    = 64'd1000000000;
  localparam logic [AW-1:0] FREQ_MAX = 64'hFF_FFFF;
  localparam logic [AW-1:0] PF_POS   = 64'd32767;
  localparam logic [AW-1:0] PF_NEG   = 64'd32768;
  localparam logic [CC_W-1:0] CC_MAX = '1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [2:0]                      state_q, state_d;
  logic [4:0]                      seq_q, seq_d;
  logic [MACC_W-1:0]               mac_cnt_q, mac_cnt_d;

  logic [acrms_pkg::VGAIN_W-1:0]   vgain_q, vgain_d;
  logic [acrms_pkg::IGAIN_W-1:0]   igain_q, igain_d;
  logic [acrms_pkg::PFMIN_W-1:0]   pfmin_q, pfmin_d;
  logic [VOLT_W-1:0]               voff_q, voff_d;
  logic [CURR_W-1:0]               ioff_q, ioff_d;

  logic [RAWV_W-1:0]               rawv_q, rawv_d;
  logic [RAWI_W-1:0]               rawi_q, rawi_d;
  logic [SQ_W-1:0]                 sqv_q, sqv_d;
  logic [SQ_W-1:0]                 sqi_q, sqi_d;
  logic [PS_W-1:0]                 ps_q, ps_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic                            wneg_q, wneg_d;
  logic                            seen_q, seen_d;
  logic                            drop_q, drop_d;
  logic [TIME_W-1:0]               last_t_q, last_t_d;
  logic [TIME_W-1:0]               per_q, per_d;
  logic [CC_W-1:0]                 cc_q, cc_d;

  logic                            wend_q, wend_d;
  logic                            pneg_q, pneg_d;
  logic [MAG_W-1:0]                mv_q, mv_d;
  logic [MAG_W-1:0]                mi_q, mi_d;
  logic [PROD_W-1:0]               av_q, av_d;
  logic [PROD_W-1:0]               ai_q, ai_d;
  logic [PROD_W-1:0]               pv_q, pv_d;
  logic [PROD_W-1:0]               pi_q, pi_d;
  logic [PROD_W-1:0]               pp_q, pp_d;

  logic [AW-1:0]                   tmp_q, tmp_d;
  logic [AW-1:0]                   den_q, den_d;
  logic [AW-1:0]                   scaled_q, scaled_d;
  logic [AW-1:0]                   va_q, va_d;
  logic [31:0]                     rv_q, rv_d;
  logic [31:0]                     ri_q, ri_d;
  logic [acrms_pkg::ACT_W-1:0]     act_q, act_d;
  logic [acrms_pkg::APP_W-1:0]     app_q, app_d;
  logic [acrms_pkg::PF_W-1:0]      pf_q, pf_d;
  logic                            pf_en_q, pf_en_d;
  logic [acrms_pkg::FREQ_W-1:0]    freq_q, freq_d;
  logic [VOLT_W-1:0]               voffn_q, voffn_d;
  logic [CURR_W-1:0]               ioffn_q, ioffn_d;

  logic                            m_valid_q, m_valid_d;
  logic [acrms_pkg::M_DATA_W-1:0]  m_data_q, m_data_d;
  logic                            m_user_q, m_user_d;

  // ---------------------------------------------------------------------------
  // Working signals
  // ---------------------------------------------------------------------------
  logic [VOLT_W-1:0]      in_volt;
  logic [CURR_W-1:0]      in_curr;
  logic [TIME_W-1:0]      in_time;
  logic                   in_acc;
  logic [VOLT_W:0]        dv;
  logic [VOLT_W:0]        dv_neg;
  logic [CURR_W:0]        di;
  logic [CURR_W:0]        di_neg;
  logic [MAG_W-1:0]       vmag;
  logic [MAG_W-1:0]       imag;
  logic [TIME_W-1:0]      dt;
  logic [TIME_W:0]        per_sum;
  logic                   ps_neg;
  logic [PS_W-1:0]        ps_mag;
  logic [AW-1:0]          n_w;
  logic [AW-1:0]          r_plus1;

  acrms_pkg::arith_req_t  ar_req;
  logic [AW-1:0]          ar_a;
  logic [AW-1:0]          ar_b;
  logic                   ar_done;
  logic [AW-1:0]          ar_res;

  assign in_volt = s_axis_tdata[VOLT_W-1:0];
  assign in_curr = s_axis_tdata[VOLT_W+CURR_W-1:VOLT_W];
  assign in_time = s_axis_tdata[VOLT_W+CURR_W+TIME_W-1:VOLT_W+CURR_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Offset removal and magnitudes
  assign dv     = {1'b0, in_volt} - {1'b0, voff_q};
  assign dv_neg = ~dv + 1'b1;
  assign di     = {1'b0, in_curr} - {1'b0, ioff_q};
  assign di_neg = ~di + 1'b1;
  assign vmag   = dv[VOLT_W] ? dv_neg[MAG_W-1:0] : dv[MAG_W-1:0];
  assign imag   = di[CURR_W] ? di_neg[MAG_W-1:0] : di[MAG_W-1:0];

  // Crossing period, saturating
  assign dt      = in_time - last_t_q;
  assign per_sum = {1'b0, per_q} + {1'b0, dt};

  assign ps_neg  = ps_q[PS_W-1];
  assign ps_mag  = ps_neg ? (~ps_q + 1'b1) : ps_q;
  assign n_w     = AW'(cnt_q);
  assign r_plus1 = ar_res + 1'b1;

  // ---------------------------------------------------------------------------
  // Window-end operand selection
  // ---------------------------------------------------------------------------
  always_comb begin
    ar_req.start = (state_q == ST_END);
    ar_req.op    = acrms_pkg::OP_MUL;
    ar_a         = '0;
    ar_b         = '0;
    case (seq_q)
      SP_GV2: begin
        ar_a = AW'(vgain_q);
        ar_b = AW'(vgain_q);
      end
      SP_SV: begin
        ar_a = tmp_q;
        ar_b = AW'(sqv_q);
      end
      SP_D100: begin
        ar_a = n_w;
        ar_b = K_100;
      end
      SP_QV: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = tmp_q << 2;
        ar_b      = den_q;
      end
      SP_RTV: begin
        ar_req.op = acrms_pkg::OP_SQRT;
        ar_a      = tmp_q;
      end
      SP_GI2: begin
        ar_a = AW'(igain_q);
        ar_b = AW'(igain_q);
      end
      SP_SI: begin
        ar_a = tmp_q;
        ar_b = AW'(sqi_q);
      end
      SP_QI: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = tmp_q << 2;
        ar_b      = n_w;
      end
      SP_RTI: begin
        ar_req.op = acrms_pkg::OP_SQRT;
        ar_a      = tmp_q;
      end
      SP_PV: begin
        ar_a = AW'(ps_mag);
        ar_b = AW'(vgain_q);
      end
      SP_SCALE: begin
        ar_a = tmp_q;
        ar_b = AW'(igain_q);
      end
      SP_D1E5: begin
        ar_a = n_w;
        ar_b = K_100000;
      end
      SP_AMAG: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = scaled_q + (den_q >> 1);
        ar_b      = den_q;
      end
      SP_VA: begin
        ar_a = AW'(rv_q);
        ar_b = AW'(ri_q);
      end
      SP_APP: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = va_q + K_5000;
        ar_b      = K_10000;
      end
      SP_THR: begin
        ar_a = AW'(pfmin_q);
        ar_b = K_1000;
      end
      SP_D10: begin
        ar_a = n_w;
        ar_b = K_10;
      end
      SP_A5: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = scaled_q + (den_q >> 1);
        ar_b      = den_q;
      end
      SP_PF: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = (tmp_q << 15) + (va_q >> 1);
        ar_b      = va_q;
      end
      SP_E9: begin
        ar_a = AW'(cc_q);
        ar_b = K_1E9;
      end
      SP_FREQ: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = AW'(per_q) + AW'(per_q >> 1);
        ar_b      = AW'(per_q);
      end
      SP_VOFF: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = AW'(rawv_q) + (n_w >> 1);
        ar_b      = n_w;
      end
      SP_IOFF: begin
        ar_req.op = acrms_pkg::OP_DIV;
        ar_a      = AW'(rawi_q) + (n_w >> 1);
        ar_b      = n_w;
      end
      default: begin
        ar_a = '0;
      end
    endcase
    // frequency numerator is 1e9 * crossings, held in tmp
    if (seq_q == SP_FREQ) begin
      ar_a = tmp_q + AW'(per_q >> 1);
    end
  end

  acrms_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ar_req),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .done_o (ar_done),
    .res_o  (ar_res)
  );

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    seq_d     = seq_q;
    mac_cnt_d = mac_cnt_q;
    vgain_d   = vgain_q;
    igain_d   = igain_q;
    pfmin_d   = pfmin_q;
    voff_d    = voff_q;
    ioff_d    = ioff_q;
    rawv_d    = rawv_q;
    rawi_d    = rawi_q;
    sqv_d     = sqv_q;
    sqi_d     = sqi_q;
    ps_d      = ps_q;
    cnt_d     = cnt_q;
    wneg_d    = wneg_q;
    seen_d    = seen_q;
    drop_d    = drop_q;
    last_t_d  = last_t_q;
    per_d     = per_q;
    cc_d      = cc_q;
    wend_d    = wend_q;
    pneg_d    = pneg_q;
    mv_d      = mv_q;
    mi_d      = mi_q;
    av_d      = av_q;
    ai_d      = ai_q;
    pv_d      = pv_q;
    pi_d      = pi_q;
    pp_d      = pp_q;
    tmp_d     = tmp_q;
    den_d     = den_q;
    scaled_d  = scaled_q;
    va_d      = va_q;
    rv_d      = rv_q;
    ri_d      = ri_q;
    act_d     = act_q;
    app_d     = app_q;
    pf_d      = pf_q;
    pf_en_d   = pf_en_q;
    freq_d    = freq_q;
    voffn_d   = voffn_q;
    ioffn_d   = ioffn_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    // drop the result word once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_VGAIN: vgain_d = cfg_wdata_i[acrms_pkg::VGAIN_W-1:0];
        REG_IGAIN: igain_d = cfg_wdata_i[acrms_pkg::IGAIN_W-1:0];
        REG_PFMIN: pfmin_d = cfg_wdata_i[acrms_pkg::PFMIN_W-1:0];
        default: begin
          vgain_d = vgain_q;
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wend_d = s_axis_tlast;
          seq_d  = SP_GV2;
          if (cnt_q == CNT_W'(MAX_WINDOW_SAMPLES)) begin
            // window full: drop the word, still honor its window end
            drop_d = 1'b1;
            if (s_axis_tlast) begin
              state_d = ST_END;
            end
          end else begin
            rawv_d    = rawv_q + RAWV_W'(in_volt);
            rawi_d    = rawi_q + RAWI_W'(in_curr);
            cnt_d     = cnt_q + 1'b1;
            pneg_d    = dv[VOLT_W] ^ di[CURR_W];
            mv_d      = vmag;
            mi_d      = imag;
            av_d      = PROD_W'(vmag);
            ai_d      = PROD_W'(imag);
            pv_d      = '0;
            pi_d      = '0;
            pp_d      = '0;
            mac_cnt_d = '0;
            // rising zero crossing of the voltage
            if (wneg_q && !dv[VOLT_W]) begin
              if (seen_q) begin
                per_d = per_sum[TIME_W] ? '1 : per_sum[TIME_W-1:0];
                if (cc_q != CC_MAX) begin
                  cc_d = cc_q + 1'b1;
                end
              end
              seen_d   = 1'b1;
              last_t_d = in_time;
            end
            wneg_d  = dv[VOLT_W];
            state_d = ST_MAC;
          end
        end
      end

      ST_MAC: begin
        // one multiplier bit per cycle for dv*dv, di*di and dv*di
        if (mv_q[0]) begin
          pv_d = pv_q + av_q;
          pp_d = pp_q + ai_q;
        end
        if (mi_q[0]) begin
          pi_d = pi_q + ai_q;
        end
        mv_d      = mv_q >> 1;
        mi_d      = mi_q >> 1;
        av_d      = av_q << 1;
        ai_d      = ai_q << 1;
        mac_cnt_d = mac_cnt_q + 1'b1;
        if (mac_cnt_q == MACC_W'(MAG_W - 1)) begin
          state_d = ST_ACC;
        end
      end

      ST_ACC: begin
        sqv_d   = sqv_q + SQ_W'(pv_q);
        sqi_d   = sqi_q + SQ_W'(pi_q);
        ps_d    = pneg_q ? (ps_q - PS_W'(pp_q)) : (ps_q + PS_W'(pp_q));
        state_d = wend_q ? ST_END : ST_IDLE;
      end

      ST_END: begin
        state_d = ST_WAIT;
      end

      ST_WAIT: begin
        if (ar_done) begin
          case (seq_q)
            SP_GV2, SP_SV, SP_QV, SP_GI2, SP_SI, SP_QI, SP_PV, SP_A5, SP_E9: begin
              tmp_d = ar_res;
            end
            SP_D100, SP_D1E5, SP_D10: begin
              den_d = ar_res;
            end
            SP_RTV: rv_d = r_plus1[32:1];
            SP_RTI: ri_d = r_plus1[32:1];
            SP_SCALE: scaled_d = ar_res;
            SP_AMAG: begin
              act_d = ps_neg ? (~ar_res[acrms_pkg::ACT_W-1:0] + 1'b1)
                             : ar_res[acrms_pkg::ACT_W-1:0];
            end
            SP_VA: va_d = ar_res;
            SP_APP: app_d = ar_res[acrms_pkg::APP_W-1:0];
            SP_THR: pf_en_d = (va_q > ar_res);
            SP_PF: begin
              if (!pf_en_q) begin
                pf_d = '0;
              end else if (ps_neg) begin
                pf_d = (ar_res > PF_NEG) ? PF_NEG[acrms_pkg::PF_W-1:0]
                                         : (~ar_res[acrms_pkg::PF_W-1:0] + 1'b1);
              end else begin
                pf_d = (ar_res > PF_POS) ? PF_POS[acrms_pkg::PF_W-1:0]
                                         : ar_res[acrms_pkg::PF_W-1:0];
              end
            end
            SP_FREQ: begin
              if (cc_q == '0) begin
                freq_d = '0;
              end else if (per_q == '0 || ar_res > FREQ_MAX) begin
                freq_d = FREQ_MAX[acrms_pkg::FREQ_W-1:0];
              end else begin
                freq_d = ar_res[acrms_pkg::FREQ_W-1:0];
              end
            end
            SP_VOFF: voffn_d = ar_res[VOLT_W-1:0];
            SP_IOFF: ioffn_d = ar_res[CURR_W-1:0];
            default: begin
              tmp_d = tmp_q;
            end
          endcase
          if (seq_q == SP_IOFF) begin
            state_d = ST_EMIT;
          end else begin
            seq_d   = seq_q + 1'b1;
            state_d = ST_END;
          end
        end
      end

      ST_EMIT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = drop_q;
          // keep field order: count, rms voltage, rms current, ...
          m_data_d  = {2'b00, freq_q, pf_q, app_q, act_q,
                       ri_q[acrms_pkg::RI_W-1:0], rv_q[acrms_pkg::RV_W-1:0],
                       n_w[acrms_pkg::SC_W-1:0]};
          voff_d   = voffn_q;
          ioff_d   = ioffn_q;
          rawv_d   = '0;
          rawi_d   = '0;
          sqv_d    = '0;
          sqi_d    = '0;
          ps_d     = '0;
          cnt_d    = '0;
          wneg_d   = 1'b0;
          seen_d   = 1'b0;
          drop_d   = 1'b0;
          last_t_d = '0;
          per_d    = '0;
          cc_d     = '0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seq_q     <= SP_GV2;
      mac_cnt_q <= '0;
      vgain_q   <= acrms_pkg::VGAIN_RST;
      igain_q   <= acrms_pkg::IGAIN_RST;
      pfmin_q   <= acrms_pkg::PFMIN_RST;
      voff_q    <= acrms_pkg::OFFSET_RST;
      ioff_q    <= acrms_pkg::OFFSET_RST;
      rawv_q    <= '0;
      rawi_q    <= '0;
      sqv_q     <= '0;
      sqi_q     <= '0;
      ps_q      <= '0;
      cnt_q     <= '0;
      wneg_q    <= 1'b0;
      seen_q    <= 1'b0;
      drop_q    <= 1'b0;
      last_t_q  <= '0;
      per_q     <= '0;
      cc_q      <= '0;
      wend_q    <= 1'b0;
      pf_en_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      seq_q     <= seq_d;
      mac_cnt_q <= mac_cnt_d;
      vgain_q   <= vgain_d;
      igain_q   <= igain_d;
      pfmin_q   <= pfmin_d;
      voff_q    <= voff_d;
      ioff_q    <= ioff_d;
      rawv_q    <= rawv_d;
      rawi_q    <= rawi_d;
      sqv_q     <= sqv_d;
      sqi_q     <= sqi_d;
      ps_q      <= ps_d;
      cnt_q     <= cnt_d;
      wneg_q    <= wneg_d;
      seen_q    <= seen_d;
      drop_q    <= drop_d;
      last_t_q  <= last_t_d;
      per_q     <= per_d;
      cc_q      <= cc_d;
      wend_q    <= wend_d;
      pf_en_q   <= pf_en_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pneg_q   <= pneg_d;
    mv_q     <= mv_d;
    mi_q     <= mi_d;
    av_q     <= av_d;
    ai_q     <= ai_d;
    pv_q     <= pv_d;
    pi_q     <= pi_d;
    pp_q     <= pp_d;
    tmp_q    <= tmp_d;
    den_q    <= den_d;
    scaled_q <= scaled_d;
    va_q     <= va_d;
    rv_q     <= rv_d;
    ri_q     <= ri_d;
    act_q    <= act_d;
    app_q    <= app_d;
    pf_q     <= pf_d;
    freq_q   <= freq_d;
    voffn_q  <= voffn_d;
    ioffn_q  <= ioffn_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

### design/acrms_checker.sv
// ----------------------------------------------------------------------------
// AC RMS power meter port checker
// Watches the result stream of the top level for holding and consistency.
// ----------------------------------------------------------------------------
`include "ac_rms_power_meter_macros.svh"

module acrms_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [acrms_pkg::M_DATA_W-1:0]    m_axis_tdata,
  input logic                              m_axis_tuser
);

  `ACRMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")

  `ACRMS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  `ACRMS_ASSERT_NOW(a_count_nonzero, m_axis_tvalid, m_axis_tdata[12:0] != 13'd0, "result with empty window")

  `ACRMS_ASSERT_NOW(a_pf_no_current, m_axis_tvalid && (m_axis_tdata[50:31] == 20'd0), m_axis_tdata[117:102] == 16'd0, "power factor set without current")

endmodule

bind ac_rms_power_meter acrms_checker u_acrms_checker (.*);
